/* src/bounded_min_group_priority_queue_macros.svh */
// Assertion macros for the bounded min group priority queue.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BOUNDED_MIN_GROUP_PRIORITY_QUEUE_MACROS_SVH
`define BOUNDED_MIN_GROUP_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTH
`define BMGPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BMGPQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define BMGPQ_ASSERT(lbl, prop, msg)
`define BMGPQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* src/bmgpq_pkg.sv */
// Shared types and constants of the bounded min group priority queue.
// No dependencies.
package bmgpq_pkg;
	localparam int KEY_W = 32;
	localparam int VTX_W = 16;
	localparam int TOL_W = 16;
	localparam int CAP   = 64;
	localparam int IDX_W = $clog2(CAP);
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int ENT_W = KEY_W + VTX_W;

	typedef enum logic [2:0] {
		ST_ITEM     = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_ABOVE    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SCAN_CLASSIFY,
		SCAN_SELECT,
		SCAN_COMPACT
	} scan_mode_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_PULL   = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_UPPER_BOUND = 1'b0;
	localparam logic REG_TOLERANCE   = 1'b1;

	typedef struct packed {
		logic       insert;
		logic       clear_min;
		logic       scan_start;
		scan_mode_t mode;
		logic       mark_sent;
		logic       commit;
		logic       load_out;
		logic       out_group;
		status_t    out_status;
	} cmd_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic             above;
		logic             scan_busy;
		logic             grp_one;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} sts_t;
endpackage

/* src/bmgpq_ram.sv */
// Generic single write, single read RAM with registered read data.
// No dependencies.
module bmgpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* src/bmgpq_datapath.sv */
// Datapath: entry memory, scan engine, group flags, tracked minimum, result register.
// Depends on bmgpq_pkg and bmgpq_ram.
module bmgpq_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bmgpq_pkg::cmd_t            cmd,
	output bmgpq_pkg::sts_t            sts,
	input  logic [bmgpq_pkg::VTX_W-1:0] in_vertex,
	input  logic [bmgpq_pkg::KEY_W-1:0] in_key,
	input  logic [bmgpq_pkg::KEY_W-1:0] upper_bound,
	input  logic [bmgpq_pkg::TOL_W-1:0] key_tolerance,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [2:0]                 out_status,
	output logic [bmgpq_pkg::VTX_W-1:0] out_vertex,
	output logic [bmgpq_pkg::KEY_W-1:0] out_key,
	output logic                       out_last,
	output logic [bmgpq_pkg::KEY_W-1:0] out_bound,
	output logic                       out_not_empty,
	output logic [bmgpq_pkg::KEY_W-1:0] out_min
);
	localparam int KW = bmgpq_pkg::KEY_W;
	localparam int VW = bmgpq_pkg::VTX_W;
	localparam int IW = bmgpq_pkg::IDX_W;
	localparam int CW = bmgpq_pkg::CNT_W;
	localparam int EW = bmgpq_pkg::ENT_W;

	logic [CW-1:0] count_q, rd_idx_q, wp_q, rem_cnt_q, grp_left_q;
	logic [KW-1:0] min_q, rem_min_q, best_key_q;
	logic [VW-1:0] best_vtx_q;
	logic [IW-1:0] best_idx_q, idx_s1;
	logic          found_q, scanning_q, vld_s1;
	bmgpq_pkg::scan_mode_t mode_q;
	logic [bmgpq_pkg::CAP-1:0] keep_q, sent_q;

	logic          we;
	logic [IW-1:0] waddr;
	logic [EW-1:0] wdata, rdata;
	logic [KW-1:0] rkey;
	logic [VW-1:0] rvtx;
	logic          in_grp;
	logic [KW:0]   limit;

	assign rkey   = rdata[EW-1:VW];
	assign rvtx   = rdata[VW-1:0];
	assign in_grp = (rkey - min_q) <= {{(KW-bmgpq_pkg::TOL_W){1'b0}}, key_tolerance};
	assign limit  = {1'b0, upper_bound} + {{(KW+1-bmgpq_pkg::TOL_W){1'b0}}, key_tolerance};

	// inserts write at the fill level, compaction at the trailing write pointer
	always_comb begin
		we    = 1'b0;
		waddr = wp_q[IW-1:0];
		wdata = rdata;
		if (cmd.insert) begin
			we    = 1'b1;
			waddr = count_q[IW-1:0];
			wdata = {in_key, in_vertex};
		end else if (vld_s1 && mode_q == bmgpq_pkg::SCAN_COMPACT && keep_q[idx_s1]) begin
			we = 1'b1;
		end
	end

	bmgpq_ram #(.WIDTH(EW), .DEPTH(bmgpq_pkg::CAP)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q <= 1'b0;
			vld_s1     <= 1'b0;
			rd_idx_q   <= '0;
			idx_s1     <= '0;
			mode_q     <= bmgpq_pkg::SCAN_CLASSIFY;
		end else begin
			vld_s1 <= 1'b0;
			if (cmd.scan_start) begin
				scanning_q <= 1'b1;
				rd_idx_q   <= '0;
				mode_q     <= cmd.mode;
			end else if (scanning_q) begin
				if (rd_idx_q < count_q) begin
					vld_s1   <= 1'b1;
					idx_s1   <= rd_idx_q[IW-1:0];
					rd_idx_q <= rd_idx_q + 1'b1;
				end else begin
					scanning_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			min_q      <= '1;
			rem_cnt_q  <= '0;
			rem_min_q  <= '1;
			grp_left_q <= '0;
			wp_q       <= '0;
			found_q    <= 1'b0;
			best_key_q <= '0;
			best_vtx_q <= '0;
			best_idx_q <= '0;
			keep_q     <= '0;
			sent_q     <= '0;
		end else begin
			if (cmd.scan_start) begin
				unique case (cmd.mode)
					bmgpq_pkg::SCAN_CLASSIFY: begin
						rem_cnt_q  <= '0;
						rem_min_q  <= '1;
						grp_left_q <= '0;
					end
					bmgpq_pkg::SCAN_SELECT: found_q <= 1'b0;
					bmgpq_pkg::SCAN_COMPACT: wp_q <= '0;
					default: found_q <= 1'b0;
				endcase
			end
			if (vld_s1) begin
				unique case (mode_q)
					bmgpq_pkg::SCAN_CLASSIFY: begin
						keep_q[idx_s1] <= !in_grp;
						sent_q[idx_s1] <= 1'b0;
						if (in_grp) begin
							grp_left_q <= grp_left_q + 1'b1;
						end else begin
							rem_cnt_q <= rem_cnt_q + 1'b1;
							if (rkey < rem_min_q) begin
								rem_min_q <= rkey;
							end
						end
					end
					bmgpq_pkg::SCAN_SELECT: begin
						// strict compare keeps the earliest position on a tie
						if (!keep_q[idx_s1] && !sent_q[idx_s1] && (!found_q || rkey < best_key_q)) begin
							found_q    <= 1'b1;
							best_key_q <= rkey;
							best_vtx_q <= rvtx;
							best_idx_q <= idx_s1;
						end
					end
					bmgpq_pkg::SCAN_COMPACT: begin
						if (keep_q[idx_s1]) begin
							wp_q <= wp_q + 1'b1;
						end
					end
					default: found_q <= found_q;
				endcase
			end
			if (cmd.mark_sent) begin
				sent_q[best_idx_q] <= 1'b1;
				grp_left_q         <= grp_left_q - 1'b1;
			end
			if (cmd.insert) begin
				count_q <= count_q + 1'b1;
				if (in_key < min_q) begin
					min_q <= in_key;
				end
			end else if (cmd.clear_min) begin
				min_q <= '1;
			end else if (cmd.commit) begin
				count_q <= rem_cnt_q;
				min_q   <= rem_min_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid     <= 1'b0;
			out_status    <= '0;
			out_vertex    <= '0;
			out_key       <= '0;
			out_last      <= 1'b0;
			out_bound     <= '0;
			out_not_empty <= 1'b0;
			out_min       <= '0;
		end else if (cmd.load_out) begin
			out_valid  <= 1'b1;
			out_status <= cmd.out_status;
			out_bound  <= upper_bound;
			if (cmd.out_group) begin
				out_vertex    <= best_vtx_q;
				out_key       <= best_key_q;
				out_last      <= (grp_left_q == CW'(1));
				out_not_empty <= (rem_cnt_q != '0);
				out_min       <= rem_min_q;
			end else begin
				out_vertex    <= '0;
				out_key       <= '0;
				out_last      <= 1'b1;
				out_not_empty <= (count_q != '0);
				out_min       <= min_q;
			end
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	assign sts.full      = (count_q == CW'(bmgpq_pkg::CAP));
	assign sts.empty     = (count_q == '0);
	assign sts.above     = {1'b0, min_q} > limit;
	assign sts.scan_busy = scanning_q | vld_s1;
	assign sts.grp_one   = (grp_left_q == CW'(1));
	assign sts.out_free  = !out_valid | out_ready;
	assign sts.count     = count_q;
endmodule

/* src/bmgpq_ctrl.sv */
// Controller state machine: sequences inserts, pulls, group scans and results.
// Depends on bmgpq_pkg.
module bmgpq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_op,
	output logic            in_ready,
	input  bmgpq_pkg::sts_t sts,
	output bmgpq_pkg::cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_CLASSIFY,
		S_SELECT,
		S_EMIT,
		S_COMPACT,
		S_RESP
	} state_t;

	state_t              state_q, state_d;
	bmgpq_pkg::status_t  rsp_q, rsp_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		rsp_d   = rsp_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					priority if (in_op == bmgpq_pkg::OP_INSERT) begin
						state_d = S_RESP;
						if (sts.full) begin
							rsp_d = bmgpq_pkg::ST_FULL;
						end else begin
							rsp_d      = bmgpq_pkg::ST_INSERTED;
							cmd.insert = 1'b1;
						end
					end else if (sts.empty) begin
						state_d       = S_RESP;
						rsp_d         = bmgpq_pkg::ST_EMPTY;
						cmd.clear_min = 1'b1;
					end else if (sts.above) begin
						state_d = S_RESP;
						rsp_d   = bmgpq_pkg::ST_ABOVE;
					end else begin
						state_d        = S_CLASSIFY;
						cmd.scan_start = 1'b1;
						cmd.mode       = bmgpq_pkg::SCAN_CLASSIFY;
					end
				end
			end
			S_CLASSIFY: begin
				if (!sts.scan_busy) begin
					state_d        = S_SELECT;
					cmd.scan_start = 1'b1;
					cmd.mode       = bmgpq_pkg::SCAN_SELECT;
				end
			end
			S_SELECT: begin
				if (!sts.scan_busy) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out   = 1'b1;
					cmd.out_group  = 1'b1;
					cmd.out_status = bmgpq_pkg::ST_ITEM;
					cmd.mark_sent  = 1'b1;
					cmd.scan_start = 1'b1;
					if (sts.grp_one) begin
						state_d  = S_COMPACT;
						cmd.mode = bmgpq_pkg::SCAN_COMPACT;
					end else begin
						state_d  = S_SELECT;
						cmd.mode = bmgpq_pkg::SCAN_SELECT;
					end
				end
			end
			S_COMPACT: begin
				if (!sts.scan_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.load_out   = 1'b1;
					cmd.out_status = rsp_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_q   <= bmgpq_pkg::ST_ITEM;
		end else begin
			state_q <= state_d;
			rsp_q   <= rsp_d;
		end
	end
endmodule

/* src/bounded_min_group_priority_queue.sv */
// Bounded min priority queue of up to 64 vertex/key pairs with group pull.
// A pull that extracts a group of entries makes one pass over the entry
// memory to mark the group and find the new minimum, one pass per extracted
// entry to pick the next smallest, and one pass to compact the survivors.
// Every pass reads the entry memory one entry a cycle. Empty, full and
// above-bound cases answer without a scan. Inputs are taken only between
// requests; the result register lets the next request enter while the last
// result waits.
// Depends on bmgpq_pkg, bmgpq_ctrl, bmgpq_datapath and the macros header.
`include "bounded_min_group_priority_queue_macros.svh"
module bounded_min_group_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [47:0]   s_axis_tdata,  // vertex[15:0], key[47:16]
	input  logic          s_axis_tuser,  // operation
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// out_vertex[15:0], out_key[47:16], current_bound[79:48],
	// not_empty[80], min_key_now[112:81], zero[119:113]
	output logic [119:0]  m_axis_tdata,
	output logic [2:0]    m_axis_tuser,  // status
	output logic          m_axis_tlast,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	logic [bmgpq_pkg::KEY_W-1:0] upper_bound_q;
	logic [bmgpq_pkg::TOL_W-1:0] tolerance_q;
	bmgpq_pkg::cmd_t cmd;
	bmgpq_pkg::sts_t sts;
	logic [bmgpq_pkg::VTX_W-1:0] o_vertex;
	logic [bmgpq_pkg::KEY_W-1:0] o_key, o_bound, o_min;
	logic o_not_empty;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == bmgpq_pkg::REG_UPPER_BOUND) ? upper_bound_q
		: {16'd0, tolerance_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_bound_q <= '1;
			tolerance_q   <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				bmgpq_pkg::REG_UPPER_BOUND: upper_bound_q <= pwdata;
				bmgpq_pkg::REG_TOLERANCE:   tolerance_q   <= pwdata[15:0];
				default:                    tolerance_q   <= tolerance_q;
			endcase
		end
	end

	bmgpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmgpq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_vertex     (s_axis_tdata[15:0]),
		.in_key        (s_axis_tdata[47:16]),
		.upper_bound   (upper_bound_q),
		.key_tolerance (tolerance_q),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_status    (m_axis_tuser),
		.out_vertex    (o_vertex),
		.out_key       (o_key),
		.out_last      (m_axis_tlast),
		.out_bound     (o_bound),
		.out_not_empty (o_not_empty),
		.out_min       (o_min)
	);

	assign m_axis_tdata = {7'd0, o_min, o_not_empty, o_bound, o_key, o_vertex};

	`BMGPQ_ASSERT(a_count_bound, sts.count <= 7'(bmgpq_pkg::CAP), "entry count above capacity")
	`BMGPQ_ASSERT(a_idle_no_scan, !(s_axis_tready && sts.scan_busy), "scan running while idle")
	`BMGPQ_ASSERT(a_load_free, !(cmd.load_out && !sts.out_free), "result overwritten")
	`BMGPQ_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request not held off")
endmodule

/* bench/bounded_min_group_priority_queue_tb.sv */
// Self-checking bench for the bounded min group priority queue.
// Runs directed and random insert/pull requests under several idling mixes and
// register settings. Depends on bmgpq_pkg and bounded_min_group_priority_queue.
`timescale 1ns / 100ps
module bounded_min_group_priority_queue_tb;
	localparam int KEY_W = bmgpq_pkg::KEY_W;
	localparam int VTX_W = bmgpq_pkg::VTX_W;
	localparam int TOL_W = bmgpq_pkg::TOL_W;
	localparam int CAP   = bmgpq_pkg::CAP;

	localparam int GROUP_MAX  = 64;
	localparam int STALL_LIMIT = 40000;
	localparam logic [2:0] ADDR_BOUND = {bmgpq_pkg::REG_UPPER_BOUND, 2'b00};
	localparam logic [2:0] ADDR_TOL   = {bmgpq_pkg::REG_TOLERANCE, 2'b00};

	typedef struct {
		logic [KEY_W-1:0] key;
		logic [VTX_W-1:0] vtx;
	} slot_t;

	typedef struct {
		bmgpq_pkg::status_t st;
		logic [VTX_W-1:0]   vtx;
		logic [KEY_W-1:0]   key;
		logic               last;
		logic [KEY_W-1:0]   bnd;
		logic               not_empty;
		logic [KEY_W-1:0]   min_now;
	} result_t;

	typedef struct {
		logic               op;
		logic [VTX_W-1:0]   vtx;
		logic [KEY_W-1:0]   key;
		logic               check_st;
		bmgpq_pkg::status_t st;
	} row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [47:0]   s_axis_tdata = '0;  // vertex[15:0], key[47:16]
	logic          s_axis_tuser = 1'b0; // operation
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	// out_vertex[15:0], out_key[47:16], current_bound[79:48],
	// not_empty[80], min_key_now[112:81], zero[119:113]
	logic [119:0]  m_axis_tdata;
	logic [2:0]    m_axis_tuser;        // status
	logic          m_axis_tlast;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [2:0]    paddr = '0;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;

	bounded_min_group_priority_queue u_top (.*);

	// queue mirror and register copies
	slot_t            stored[$];
	logic [KEY_W-1:0] min_key_mirror;
	logic [KEY_W-1:0] bound_reg;
	logic [TOL_W-1:0] tol_reg;
	result_t          pending[$];

	int src_idle_pct;
	int snk_stall_pct;
	int errors;
	int n_requests;
	int n_results;
	int n_extracted;
	int quiet_cycles;
	logic [KEY_W-1:0] key_base;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	function automatic int smallest_pos();
		int best;
		best = 0;
		for (int i = 1; i < stored.size(); i++)
			if (stored[i].key < stored[best].key)
				best = i;
		return best;
	endfunction

	// Work out the results of one request and queue them; returns the first status.
	function automatic bmgpq_pkg::status_t predict_request(input logic op,
			input logic [VTX_W-1:0] vtx, input logic [KEY_W-1:0] key);
		result_t group[$];
		result_t r;
		slot_t slot;
		logic [KEY_W-1:0] base;
		int p;
		r = '{bmgpq_pkg::ST_ITEM, '0, '0, 1'b0, bound_reg, 1'b0, '0};
		if (op == bmgpq_pkg::OP_INSERT) begin
			if (stored.size() >= CAP) begin
				r.st = bmgpq_pkg::ST_FULL;
			end else begin
				slot.key = key;
				slot.vtx = vtx;
				stored = {stored, slot};
				if (key < min_key_mirror)
					min_key_mirror = key;
				r.st = bmgpq_pkg::ST_INSERTED;
			end
			group = {group, r};
		end else if (stored.size() == 0) begin
			min_key_mirror = '1;
			r.st = bmgpq_pkg::ST_EMPTY;
			group = {group, r};
		end else begin
			base = stored[smallest_pos()].key;
			if (base > bound_reg && (base - bound_reg) > {16'd0, tol_reg}) begin
				r.st = bmgpq_pkg::ST_ABOVE;
				group = {group, r};
			end else begin
				while (stored.size() != 0 && group.size() < GROUP_MAX) begin
					p = smallest_pos();
					if (stored[p].key - base > {16'd0, tol_reg})
						break;
					r.vtx = stored[p].vtx;
					r.key = stored[p].key;
					group = {group, r};
					stored.delete(p);
				end
				min_key_mirror = stored.size() != 0 ? stored[smallest_pos()].key : '1;
			end
		end
		foreach (group[i]) begin
			group[i].last = (i == group.size() - 1);
			group[i].not_empty = stored.size() != 0;
			group[i].min_now = min_key_mirror;
			pending = {pending, group[i]};
		end
		return group[0].st;
	endfunction

	// Drive one request and hold it until taken.
	task automatic send(input logic op, input logic [VTX_W-1:0] vtx, input logic [KEY_W-1:0] key,
			output bmgpq_pkg::status_t first_st);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {key, vtx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		first_st = predict_request(op, vtx, key);
		n_requests++;
	endtask

	// hold until every result is out and the queue is back at rest
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0 || !s_axis_tready)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == ADDR_BOUND)
			bound_reg = data;
		else
			tol_reg = data[TOL_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_request();
		bmgpq_pkg::status_t st;
		logic op;
		logic [KEY_W-1:0] key;
		int r;
		op = ($urandom_range(0, 99) < 30) ? bmgpq_pkg::OP_PULL : bmgpq_pkg::OP_INSERT;
		r = $urandom_range(0, 99);
		if (r < 60)
			key = key_base + $urandom_range(0, 40000);
		else if (r < 85)
			key = $urandom;
		else
			case ($urandom_range(0, 3))
				0: key = '0;
				1: key = '1;
				2: key = bound_reg;
				default: key = bound_reg + tol_reg;
			endcase
		send(op, 16'($urandom_range(0, 65535)), key, st);
	endtask

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pending.size() == 0) begin
				report("unexpected result", m_axis_tuser, 0);
			end else begin
				e = pending.pop_front();
				if (e.st == bmgpq_pkg::ST_ITEM)
					n_extracted++;
				if (m_axis_tuser != e.st)
					report("status", m_axis_tuser, e.st);
				if (m_axis_tdata[15:0] != e.vtx)
					report("vertex", m_axis_tdata[15:0], e.vtx);
				if (m_axis_tdata[47:16] != e.key)
					report("key", m_axis_tdata[47:16], e.key);
				if (m_axis_tlast != e.last)
					report("last", m_axis_tlast, e.last);
				if (m_axis_tdata[79:48] != e.bnd)
					report("bound", m_axis_tdata[79:48], e.bnd);
				if (m_axis_tdata[80] != e.not_empty)
					report("not_empty", m_axis_tdata[80], e.not_empty);
				if (m_axis_tdata[112:81] != e.min_now)
					report("min_key_now", m_axis_tdata[112:81], e.min_now);
			end
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		bmgpq_pkg::status_t st;
		logic [31:0] bounds[5];
		logic [31:0] tols[5];
		errors = 0;
		n_requests = 0;
		n_results = 0;
		n_extracted = 0;
		quiet_cycles = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		bound_reg = '1;
		tol_reg = '0;
		min_key_mirror = '1;
		rows = '{
			'{bmgpq_pkg::OP_PULL,   16'h0000, 32'h0000_0000, 1'b1, bmgpq_pkg::ST_EMPTY},
			'{bmgpq_pkg::OP_INSERT, 16'h0000, 32'hFFFF_FFFF, 1'b1, bmgpq_pkg::ST_INSERTED},
			'{bmgpq_pkg::OP_INSERT, 16'hFFFF, 32'h0000_0000, 1'b1, bmgpq_pkg::ST_INSERTED},
			'{bmgpq_pkg::OP_INSERT, 16'h0001, 32'h0000_0005, 1'b1, bmgpq_pkg::ST_INSERTED},
			'{bmgpq_pkg::OP_INSERT, 16'h0002, 32'h0000_0005, 1'b1, bmgpq_pkg::ST_INSERTED},
			'{bmgpq_pkg::OP_PULL,   16'h1234, 32'h9999_9999, 1'b1, bmgpq_pkg::ST_ITEM},
			'{bmgpq_pkg::OP_PULL,   16'h0000, 32'h0000_0000, 1'b1, bmgpq_pkg::ST_ITEM},
			'{bmgpq_pkg::OP_PULL,   16'h0000, 32'h0000_0000, 1'b1, bmgpq_pkg::ST_ITEM},
			'{bmgpq_pkg::OP_PULL,   16'h0000, 32'h0000_0000, 1'b1, bmgpq_pkg::ST_EMPTY},
			'{bmgpq_pkg::OP_INSERT, 16'hAAAA, 32'h5555_5555, 1'b0, bmgpq_pkg::ST_ITEM},
			'{bmgpq_pkg::OP_INSERT, 16'h5555, 32'hAAAA_AAAA, 1'b0, bmgpq_pkg::ST_ITEM},
			'{bmgpq_pkg::OP_INSERT, 16'h0003, 32'h5555_5555, 1'b0, bmgpq_pkg::ST_ITEM},
			'{bmgpq_pkg::OP_PULL,   16'h0000, 32'h0000_0000, 1'b0, bmgpq_pkg::ST_ITEM},
			'{bmgpq_pkg::OP_PULL,   16'h0000, 32'h0000_0000, 1'b0, bmgpq_pkg::ST_ITEM},
			'{bmgpq_pkg::OP_PULL,   16'h0000, 32'h0000_0000, 1'b0, bmgpq_pkg::ST_ITEM}
		};
		bounds = '{32'd0, 32'd0, $urandom, 32'hFFFF_FFFF, 32'h8000_0000};
		tols = '{32'd0, 32'hFFFF, $urandom_range(0, 65535), 32'hFFFF, 32'd1};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			send(rows[i].op, rows[i].vtx, rows[i].key, st);
			if (rows[i].check_st && st != rows[i].st)
				report("directed status", st, rows[i].st);
		end
		settle();

		for (int p = 0; p < 5; p++) begin
			write_reg(ADDR_BOUND, bounds[p]);
			write_reg(ADDR_TOL, tols[p]);
			key_base = (bound_reg > 32'h8000) ? bound_reg - 32'h8000 : 32'd0;
			case (p % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
				default: begin src_idle_pct = 27; snk_stall_pct = 27; end
			endcase
			repeat (5) random_request();
			settle();
		end

		// drain, then fill past capacity with three nearby keys and pull the whole group
		write_reg(ADDR_BOUND, 32'hFFFF_FFFF);
		write_reg(ADDR_TOL, 32'hFFFF);
		src_idle_pct = 0;
		snk_stall_pct = 27;
		while (stored.size() != 0)
			send(bmgpq_pkg::OP_PULL, '0, '0, st);
		for (int i = 0; i <= CAP; i++)
			send(bmgpq_pkg::OP_INSERT, 16'($urandom_range(0, 65535)),
				32'h0000_1000 + 32'(i % 3), st);
		send(bmgpq_pkg::OP_PULL, '0, '0, st);
		send(bmgpq_pkg::OP_PULL, '0, '0, st);
		settle();
		repeat (20) @(posedge clk);

		$display("covered %0d requests and %0d results, %0d of them extracted entries,",
			n_requests, n_results, n_extracted);
		$display("over five register settings and four idling mixes, plus a full queue");
		if (errors == 0 && pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

/* bounded_min_group_priority_queue.f */
+incdir+src
src/bmgpq_pkg.sv
src/bmgpq_ram.sv
src/bmgpq_datapath.sv
src/bmgpq_ctrl.sv
src/bounded_min_group_priority_queue.sv
bench/bounded_min_group_priority_queue_tb.sv
